// ===== hdl/deq_pkg.sv =====
// Shared types, codes and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int DATA_W        = 32;

    localparam logic [2:0] ACT_WALK_FWD = 3'd0;
    localparam logic [2:0] ACT_WALK_BWD = 3'd1;
    localparam logic [2:0] ACT_PUSH_FRT = 3'd2;
    localparam logic [2:0] ACT_PUSH_BCK = 3'd3;
    localparam logic [2:0] ACT_POP_FRT  = 3'd4;
    localparam logic [2:0] ACT_POP_BCK  = 3'd5;
    localparam logic [2:0] ACT_REVERSE  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] item;
        logic [1:0]               status;
        logic                     last;
    } res_t;

endpackage

// ===== hdl/deq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/deq_ring_add.sv =====
// Shared ring-index adder: base plus offset, wrapped modulo the store depth.
module deq_ring_add import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  logic [SLOT_W-1:0] base,
    input  logic [SLOT_W-1:0] offset,
    output logic [SLOT_W-1:0] slot
);

    localparam logic [SLOT_W:0] DEPTH_W = (SLOT_W+1)'(DEPTH);

    logic [SLOT_W:0] sum;
    logic [SLOT_W:0] wrapped;

    assign sum     = {1'b0, base} + {1'b0, offset};
    assign wrapped = sum - DEPTH_W;
    assign slot    = (sum >= DEPTH_W) ? wrapped[SLOT_W-1:0] : sum[SLOT_W-1:0];

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// Double-ended queue: ring store, shared index adder and sequencer.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one action and a push value.
//   res channel (res_valid/res_ready/res) returns item, status and last.
//   A transaction is taken only while the sequencer is idle and the result
//   register is empty or being drained in the same cycle.
//   Push, reverse and any refused or empty action: one result, shown in the
//   cycle after acceptance. Pop: one result, from a store read into the
//   store's read register and then a load into the result register. Walk:
//   one result per stored entry, each from a store read (at acceptance for
//   the first, else in S_FETCH) and a load in S_LOAD; the walk holds the
//   block until the final one, which last marks. Action code 7 is dropped
//   with no result. The single store read port and the shared ring adder
//   set this sequencing. A stalled receiver holds the result register; the
//   sequencer waits until it is free, and nothing is lost.
//   Reset empties the queue and restores natural order; entry contents are
//   left as they are and are never read before being written.
module double_ended_queue_top import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_LOAD  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] front_reg, front_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              rev_reg, rev_next;
    logic              walk_reg, walk_next;
    logic              fwd_reg, fwd_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic              res_valid_reg;
    res_t              res_reg;

    logic              out_free;
    logic              pf;
    logic              empty;
    logic              full;
    logic [SLOT_W-1:0] occ_lo;
    logic [SLOT_W-1:0] occ_m1;
    logic              load_last;
    logic [SLOT_W-1:0] offset;
    logic [SLOT_W-1:0] slot;
    logic              rd_front;
    logic              ram_we;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_load;
    res_t              res_val;

    assign out_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign pf        = (cmd.action[0] == rev_reg);
    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == OCC_W'(DEPTH));
    assign occ_lo    = occ_reg[SLOT_W-1:0];
    assign occ_m1    = occ_lo - SLOT_W'(1);
    assign load_last = walk_reg ? (k_reg == occ_m1) : 1'b1;
    assign ram_raddr = rd_front ? front_reg : slot;

    deq_ring_add #(
        .DEPTH (DEPTH)
    ) u_ring_add (
        .base   (front_reg),
        .offset (offset),
        .slot   (slot)
    );

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (cmd.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        occ_next   = occ_reg;
        rev_next   = rev_reg;
        walk_next  = walk_reg;
        fwd_next   = fwd_reg;
        k_next     = k_reg;
        offset     = '0;
        rd_front   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        res_load   = 1'b0;
        res_val    = '{item: '0, status: ST_OK, last: 1'b1};
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    case (cmd.action)
                        ACT_WALK_FWD, ACT_WALK_BWD:
                        begin
                            if (empty)
                            begin
                                res_load       = 1'b1;
                                res_val.status = ST_EMPTY;
                            end
                            else
                            begin
                                offset     = pf ? '0 : occ_m1;
                                ram_re     = 1'b1;
                                walk_next  = 1'b1;
                                fwd_next   = pf;
                                k_next     = '0;
                                state_next = S_LOAD;
                            end
                        end
                        ACT_PUSH_FRT, ACT_PUSH_BCK:
                        begin
                            res_load = 1'b1;
                            if (full)
                            begin
                                res_val.status = ST_FULL;
                            end
                            else
                            begin
                                offset   = pf ? SLOT_W'(DEPTH - 1) : occ_lo;
                                ram_we   = 1'b1;
                                occ_next = occ_reg + OCC_W'(1);
                                if (pf)
                                begin
                                    front_next = slot;
                                end
                            end
                        end
                        ACT_POP_FRT, ACT_POP_BCK:
                        begin
                            if (empty)
                            begin
                                res_load       = 1'b1;
                                res_val.status = ST_EMPTY;
                            end
                            else
                            begin
                                offset     = pf ? SLOT_W'(1) : occ_m1;
                                ram_re     = 1'b1;
                                occ_next   = occ_reg - OCC_W'(1);
                                walk_next  = 1'b0;
                                state_next = S_LOAD;
                                if (pf)
                                begin
                                    rd_front   = 1'b1;
                                    front_next = slot;
                                end
                            end
                        end
                        ACT_REVERSE:
                        begin
                            res_load = 1'b1;
                            rev_next = ~rev_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                offset     = fwd_reg ? k_reg : (occ_m1 - k_reg);
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    res_load     = 1'b1;
                    res_val.item = ram_rdata;
                    res_val.last = load_last;
                    if (load_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + SLOT_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            rev_reg       <= 1'b0;
            walk_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            occ_reg   <= occ_next;
            rev_reg   <= rev_next;
            walk_reg  <= walk_next;
            fwd_reg   <= fwd_next;
            k_reg     <= k_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_val;
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store written and read in one cycle");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && walk_reg) |-> (OCC_W'(k_reg) < occ_reg))
        else $error("walk index past occupancy");

    a_load_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && res_valid_reg && !res_ready) |=> (state_reg == S_LOAD))
        else $error("result dropped while receiver stalls");
`endif

endmodule
